// File: rtl/core/bar_body_to_mean_range_ratio_macros.svh
// Assertion macros for the bar body to mean range ratio block.
// Included by the top level only; no other dependencies.
`ifndef BAR_BODY_TO_MEAN_RANGE_RATIO_MACROS_SVH
`define BAR_BODY_TO_MEAN_RANGE_RATIO_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication
`define BBMR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bbmr same-cycle check failed");
// Next-cycle implication
`define BBMR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bbmr next-cycle check failed");
`else
`define BBMR_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define BBMR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/core/bbmr_pkg.sv
// Shared types and constants for the bar body to mean range ratio block.
// No dependencies; compiled first.
package bbmr_pkg;

    localparam int PRICE_W = 32;          // price and range width
    localparam int N_W     = 7;           // window length width
    localparam int SUM_W   = PRICE_W + N_W;   // window sum width
    localparam int PROD_W  = PRICE_W + N_W;   // 32x7 product width
    localparam int Q_W     = 12;          // marker size width
    localparam int ALU_W   = PROD_W + Q_W;    // numerator width
    localparam int DIV_STEPS = Q_W;       // one quotient bit per step
    localparam int STEP_W  = 4;

    // 2560 = 2^11 + 2^9
    localparam int MUL_SH_HI = 11;
    localparam int MUL_SH_LO = 9;

    localparam logic [Q_W-1:0] MARKER_FULL    = Q_W'(2560);
    localparam logic [N_W-1:0] WINDOW_DEFAULT = N_W'(32);
    localparam logic [N_W-1:0] WINDOW_MIN     = N_W'(2);

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        logic [ALU_W-1:0] res;   // sum or difference
        logic             ge;    // a >= b
    } t_alu_out;

endpackage

// File: rtl/core/bbmr_if.sv
// Valid/ready channel interfaces for bars in and marker sizes out.
// Depends on bbmr_pkg for field widths.
interface bbmr_bar_if;
    logic                          valid;
    logic                          ready;
    logic [bbmr_pkg::PRICE_W-1:0]  bar_high;
    logic [bbmr_pkg::PRICE_W-1:0]  bar_low;
    logic [bbmr_pkg::PRICE_W-1:0]  bar_open;
    logic [bbmr_pkg::PRICE_W-1:0]  bar_close;

    modport source (output valid, bar_high, bar_low, bar_open, bar_close, input ready);
    modport sink   (input valid, bar_high, bar_low, bar_open, bar_close, output ready);
endinterface

interface bbmr_marker_if;
    logic                       valid;
    logic                       ready;
    logic [bbmr_pkg::Q_W-1:0]   marker_size;

    modport source (output valid, marker_size, input ready);
    modport sink   (input valid, marker_size, output ready);
endinterface

// File: rtl/core/bbmr_ring.sv
// Range history memory: one write port, one registered read port.
// Depends on bbmr_pkg for the entry width.
module bbmr_ring #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [bbmr_pkg::PRICE_W-1:0]  i_wdata,
    input  logic                          i_re,
    input  logic [AW-1:0]                 i_raddr,
    output logic [bbmr_pkg::PRICE_W-1:0]  o_rdata
);
    import bbmr_pkg::*;

    logic [PRICE_W-1:0] r_mem [DEPTH];
    logic [PRICE_W-1:0] r_rdata;

    // write the new range
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // register the read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/bbmr_alu.sv
// Shared add / compare-subtract unit used by the sum, fill, compare, numerator and division steps.
// Depends on bbmr_pkg for the operand width and result struct.
module bbmr_alu (
    input  bbmr_pkg::t_alu_op              i_op,
    input  logic [bbmr_pkg::ALU_W-1:0]     i_a,
    input  logic [bbmr_pkg::ALU_W-1:0]     i_b,
    output bbmr_pkg::t_alu_out             o_res
);
    import bbmr_pkg::*;

    logic [ALU_W:0] diff;
    logic [ALU_W-1:0] add;

    assign add  = i_a + i_b;
    assign diff = {1'b0, i_a} - {1'b0, i_b};

    // select add or subtract; borrow-out gives the compare
    always_comb begin
        o_res.ge = ~diff[ALU_W];
        unique case (i_op)
            ALU_ADD: o_res.res = add;
            ALU_SUB: o_res.res = diff[ALU_W-1:0];
            default: o_res.res = add;
        endcase
    end

endmodule

// File: rtl/core/bar_body_to_mean_range_ratio.sv
// Bar body to mean range ratio. Each accepted bar (high, low, open, close) stores its
// range |high-low| in a history memory. Bars 0 and 1 are only stored and give no result.
// From bar 2 on, the block sums the last n ranges (bars before bar 1 count as bar 1's
// range) and reports min(2560*|close-open|*n/sum, 2560), or 0 for a zero sum. n is the
// window_length register, 2..min(WINDOW_MAX, 127), with values below 2 meaning 32.
// The work runs on one shared add/subtract unit: the accept, the stored range reads
// (up to n-1, pipelined behind the memory read port, then drained), the fill, compare
// and numerator setup steps, twelve restoring division steps and the output step; the
// numerator and division steps are skipped when the ratio clamps or the sum is zero.
// The input is not ready while a bar is in work; a finished result waits in the
// output register while the next bar is taken.
`include "bar_body_to_mean_range_ratio_macros.svh"

module bar_body_to_mean_range_ratio #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [bbmr_pkg::N_W-1:0]  i_cfg_wdata,
    bbmr_bar_if.sink                  i_bar,
    bbmr_marker_if.source             o_marker
);
    import bbmr_pkg::*;

    localparam int AW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int BS_W = $clog2(WINDOW_MAX + 2);
    localparam int CW   = (BS_W > N_W) ? BS_W : N_W;
    localparam int NCAP = (WINDOW_MAX < 127) ? WINDOW_MAX : 127;
    localparam logic [N_W-1:0]  N_CAP    = N_W'(NCAP);
    localparam logic [AW-1:0]   HEAD_LAST = AW'(WINDOW_MAX - 1);
    localparam logic [BS_W-1:0] BARS_SAT  = BS_W'(WINDOW_MAX + 1);
    localparam logic [BS_W-1:0] BARS_ONE  = BS_W'(1);
    localparam logic [BS_W-1:0] BARS_TWO  = BS_W'(2);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM  = 3'd1;
    localparam logic [2:0] S_FILL = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_NUM  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]           r_state, n_state;
    logic [N_W-1:0]       r_window_length;
    logic [AW-1:0]        r_head, n_head;
    logic [BS_W-1:0]      r_bars, n_bars;
    logic [PRICE_W-1:0]   r_first, n_first;
    logic [PRICE_W-1:0]   r_body, n_body;
    logic [N_W-1:0]       r_n, n_n;
    logic [N_W-1:0]       r_real, n_real;
    logic [SUM_W-1:0]     r_acc, n_acc;
    logic [AW-1:0]        r_rptr, n_rptr;
    logic [N_W-1:0]       r_cnt, n_cnt;
    logic                 r_rvld, n_rvld;
    logic [PROD_W-1:0]    r_prod, n_prod;
    logic [ALU_W-1:0]     r_rem, n_rem;
    logic [ALU_W-1:0]     r_div, n_div;
    logic [Q_W-1:0]       r_q, n_q;
    logic [STEP_W-1:0]    r_step, n_step;
    logic                 r_out_valid, n_out_valid;
    logic [Q_W-1:0]       r_out_data, n_out_data;

    logic                 in_xfer;
    logic                 out_xfer;
    logic [PRICE_W-1:0]   range_w;
    logic [PRICE_W-1:0]   body_w;
    logic [N_W-1:0]       n_raw;
    logic [N_W-1:0]       n_eff;
    logic [N_W-1:0]       real_w;
    logic                 ring_re;
    logic [PRICE_W-1:0]   ring_rdata;
    logic [N_W-1:0]       mul_a;
    logic [PRICE_W-1:0]   mul_b;
    logic [PROD_W-1:0]    mul_p;
    t_alu_op              alu_op;
    logic [ALU_W-1:0]     alu_a;
    logic [ALU_W-1:0]     alu_b;
    t_alu_out             alu_out;

    assign in_xfer  = i_bar.valid & i_bar.ready;
    assign out_xfer = r_out_valid & o_marker.ready;

    assign i_bar.ready        = (r_state == S_IDLE);
    assign o_marker.valid     = r_out_valid;
    assign o_marker.marker_size = r_out_data;

    // range and body of the offered bar
    assign range_w = (i_bar.bar_high >= i_bar.bar_low) ? i_bar.bar_high - i_bar.bar_low
                                                       : i_bar.bar_low - i_bar.bar_high;
    assign body_w  = (i_bar.bar_open >= i_bar.bar_close) ? i_bar.bar_open - i_bar.bar_close
                                                         : i_bar.bar_close - i_bar.bar_open;

    // effective window and number of stored bars in it
    assign n_raw  = (r_window_length < WINDOW_MIN) ? WINDOW_DEFAULT : r_window_length;
    assign n_eff  = (n_raw > N_CAP) ? N_CAP : n_raw;
    assign real_w = (CW'(n_eff) <= CW'(r_bars)) ? n_eff : N_W'(r_bars);

    // range history
    bbmr_ring #(
        .DEPTH (WINDOW_MAX),
        .AW    (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (in_xfer),
        .i_waddr (r_head),
        .i_wdata (range_w),
        .i_re    (ring_re),
        .i_raddr (r_rptr),
        .o_rdata (ring_rdata)
    );

    // shared 7x32 multiplier: fill product, then body times n
    always_comb begin
        if (r_state == S_SUM) begin
            mul_a = r_n - r_real;
            mul_b = r_first;
        end else begin
            mul_a = r_n;
            mul_b = r_body;
        end
    end
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // steer the shared add/subtract unit
    always_comb begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        unique case (r_state)
            S_SUM: begin
                alu_a = ALU_W'(r_acc);
                alu_b = ALU_W'(ring_rdata);
            end
            S_FILL: begin
                alu_a = ALU_W'(r_acc);
                alu_b = ALU_W'(r_prod);
            end
            S_CMP: begin
                alu_op = ALU_SUB;
                alu_a  = ALU_W'(r_prod);
                alu_b  = ALU_W'(r_acc);
            end
            S_NUM: begin
                alu_a = ALU_W'(r_prod) << MUL_SH_HI;
                alu_b = ALU_W'(r_prod) << MUL_SH_LO;
            end
            S_DIV: begin
                alu_op = ALU_SUB;
                alu_a  = r_rem;
                alu_b  = r_div;
            end
            default: begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    bbmr_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_out)
    );

    assign ring_re = (r_state == S_SUM) && (r_cnt != '0);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_bars      = r_bars;
        n_first     = r_first;
        n_body      = r_body;
        n_n         = r_n;
        n_real      = r_real;
        n_acc       = r_acc;
        n_rptr      = r_rptr;
        n_cnt       = r_cnt;
        n_rvld      = 1'b0;
        n_prod      = r_prod;
        n_rem       = r_rem;
        n_div       = r_div;
        n_q         = r_q;
        n_step      = r_step;
        n_out_valid = out_xfer ? 1'b0 : r_out_valid;
        n_out_data  = r_out_data;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_head = (r_head == HEAD_LAST) ? '0 : r_head + AW'(1);
                    if (r_bars == BARS_ONE) begin
                        n_first = range_w;
                    end
                    if (r_bars < BARS_SAT) begin
                        n_bars = r_bars + BS_W'(1);
                    end
                    if (r_bars >= BARS_TWO) begin
                        n_body  = body_w;
                        n_n     = n_eff;
                        n_real  = real_w;
                        n_acc   = SUM_W'(range_w);
                        n_rptr  = (r_head == '0) ? HEAD_LAST : r_head - AW'(1);
                        n_cnt   = real_w - N_W'(1);
                        n_state = S_SUM;
                    end
                end
            end
            S_SUM: begin
                // issue one read per cycle, add each read's data in the next cycle
                if (ring_re) begin
                    n_rptr = (r_rptr == '0) ? HEAD_LAST : r_rptr - AW'(1);
                    n_cnt  = r_cnt - N_W'(1);
                end
                n_rvld = ring_re;
                if (r_rvld) begin
                    n_acc = alu_out.res[SUM_W-1:0];
                end
                if (!ring_re && !r_rvld) begin
                    n_prod  = mul_p;
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                n_acc   = alu_out.res[SUM_W-1:0];
                n_prod  = mul_p;
                n_state = S_CMP;
            end
            S_CMP: begin
                // zero sum gives zero; body*n >= sum clamps
                if (r_acc == '0) begin
                    n_q     = '0;
                    n_state = S_OUT;
                end else if (alu_out.ge) begin
                    n_q     = MARKER_FULL;
                    n_state = S_OUT;
                end else begin
                    n_state = S_NUM;
                end
            end
            S_NUM: begin
                n_rem   = alu_out.res;
                n_div   = ALU_W'(r_acc) << (DIV_STEPS - 1);
                n_q     = '0;
                n_step  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                // restoring division, one quotient bit per step
                if (alu_out.ge) begin
                    n_rem = alu_out.res;
                end
                n_q   = {r_q[Q_W-2:0], alu_out.ge};
                n_div = r_div >> 1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = S_OUT;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_OUT: begin
                // load the output register once it is free
                if (!r_out_valid || o_marker.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_q;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_window_length <= WINDOW_DEFAULT;
            r_head          <= '0;
            r_bars          <= '0;
            r_first         <= '0;
            r_acc           <= '0;
            r_cnt           <= '0;
            r_rvld          <= 1'b0;
            r_step          <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_bars      <= n_bars;
            r_first     <= n_first;
            r_acc       <= n_acc;
            r_cnt       <= n_cnt;
            r_rvld      <= n_rvld;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_window_length <= i_cfg_wdata;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_body     <= n_body;
        r_n        <= n_n;
        r_real     <= n_real;
        r_rptr     <= n_rptr;
        r_prod     <= n_prod;
        r_rem      <= n_rem;
        r_div      <= n_div;
        r_q        <= n_q;
        r_out_data <= n_out_data;
    end

    // checks
    `BBMR_ASSERT_NOW(a_marker_range, i_clk, i_rst_n, r_out_valid, r_out_data <= MARKER_FULL)
    `BBMR_ASSERT_NOW(a_cnt_only_in_sum, i_clk, i_rst_n, r_state != S_SUM, r_cnt == '0)
    `BBMR_ASSERT_NOW(a_div_steps, i_clk, i_rst_n, r_state == S_DIV, r_step < STEP_W'(DIV_STEPS))
    `BBMR_ASSERT_NEXT(a_early_bar_idle, i_clk, i_rst_n, in_xfer && r_bars < BARS_TWO, r_state == S_IDLE)

endmodule

// File: tb/tb_bar_body_to_mean_range_ratio.sv
// Self-checking bench for bar_body_to_mean_range_ratio: drives bars, predicts marker sizes.
// Depends on bbmr_pkg, the bbmr_bar_if / bbmr_marker_if interfaces and the block itself.
module tb_bar_body_to_mean_range_ratio;

    import bbmr_pkg::*;

    localparam int HIST_DEPTH     = 64;
    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 9;
    localparam int DRAIN_CYCLES   = 100;
    localparam int QUIET_LIMIT    = 3000;
    localparam int LONG_HOLD      = 400;
    localparam int PHASE_COUNT    = 10;
    localparam int PHASE_BARS     = 50;
    localparam int PRESSURE_PHASE = 3;
    localparam int FLAT_PHASE     = 5;
    localparam int MAX_PRINTS     = 40;

    // kinds of generated bars
    localparam int unsigned KIND_FLAT     = 0;
    localparam int unsigned KIND_EXTREME  = 1;
    localparam int unsigned KIND_INVERTED = 2;
    localparam int unsigned KIND_BIG_BODY = 3;
    localparam int unsigned KIND_LAST     = 9;

    typedef struct packed {
        logic [PRICE_W-1:0] bar_high;
        logic [PRICE_W-1:0] bar_low;
        logic [PRICE_W-1:0] bar_open;
        logic [PRICE_W-1:0] bar_close;
    } t_bar;

    // Track the block's bar history and queue the marker size each bar should give
    class marker_predictor;
        logic [PRICE_W-1:0] range_hist [HIST_DEPTH];
        int unsigned        hist_head;
        int unsigned        bars_taken;
        logic [PRICE_W-1:0] bar1_range;
        logic [N_W-1:0]     window_setting;
        logic [Q_W-1:0]     expected_markers [$];
        int unsigned        mismatches;
        int unsigned        markers_seen;

        function new();
            hist_head      = 0;
            bars_taken     = 0;
            bar1_range     = '0;
            window_setting = WINDOW_DEFAULT;
            mismatches     = 0;
            markers_seen   = 0;
        endfunction

        task report(string what);
            if (mismatches < MAX_PRINTS) begin
                $display("MISMATCH: %s", what);
            end
            mismatches++;
        endtask

        function void take_bar(t_bar b);
            logic [PRICE_W-1:0] rng;
            logic [PRICE_W-1:0] body;
            logic [63:0]        range_sum;
            logic [63:0]        ratio;
            int unsigned        prior;
            int unsigned        n;
            int unsigned        n_stored;
            rng  = (b.bar_high >= b.bar_low) ? b.bar_high - b.bar_low : b.bar_low - b.bar_high;
            body = (b.bar_open >= b.bar_close) ? b.bar_open - b.bar_close
                                               : b.bar_close - b.bar_open;
            prior = bars_taken;
            // store the range, advance the ring
            range_hist[hist_head] = rng;
            hist_head = (hist_head + 1) % HIST_DEPTH;
            if (prior == 1) begin
                bar1_range = rng;
            end
            if (bars_taken < HIST_DEPTH + 1) begin
                bars_taken++;
            end
            // bars 0 and 1 only fill the history
            if (prior < 2) begin
                return;
            end
            n = window_setting;
            if (n < WINDOW_MIN) begin
                n = WINDOW_DEFAULT;
            end
            if (n > HIST_DEPTH) begin
                n = HIST_DEPTH;
            end
            // sum the stored ranges, pad missing early bars with bar 1's range
            n_stored  = (n <= prior) ? n : prior;
            range_sum = '0;
            for (int unsigned k = 0; k < n_stored; k++) begin
                range_sum += 64'(range_hist[(hist_head + 2 * HIST_DEPTH - 1 - k) % HIST_DEPTH]);
            end
            range_sum += 64'(n - n_stored) * 64'(bar1_range);
            if (range_sum == 0) begin
                ratio = '0;
            end else begin
                ratio = (64'(MARKER_FULL) * 64'(body) * 64'(n)) / range_sum;
                if (ratio > 64'(MARKER_FULL)) begin
                    ratio = 64'(MARKER_FULL);
                end
            end
            expected_markers.push_back(ratio[Q_W-1:0]);
        endfunction

        task check_marker(logic [Q_W-1:0] got);
            logic [Q_W-1:0] want;
            markers_seen++;
            if (expected_markers.size() == 0) begin
                report($sformatf("marker_size %0d arrived with nothing expected", got));
                return;
            end
            want = expected_markers.pop_front();
            if (got !== want) begin
                report($sformatf("marker_size %0d, expected %0d (result %0d)",
                                 got, want, markers_seen));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [N_W-1:0] i_cfg_wdata;

    bbmr_bar_if    bar_ch ();
    bbmr_marker_if marker_ch ();

    marker_predictor sb;

    bit          idle_on;
    bit          hold_request;
    int unsigned long_hold;
    int unsigned bars_sent;
    int unsigned windows_used;
    int unsigned quiet_cycles;

    bar_body_to_mean_range_ratio #(
        .WINDOW_MAX (HIST_DEPTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_bar       (bar_ch),
        .o_marker    (marker_ch)
    );

    // free-running clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // window setting used in each phase
    function automatic logic [N_W-1:0] window_for_phase(input int unsigned phase);
        logic [N_W-1:0] w;
        unique case (phase)
            1:       w = N_W'(0);
            2:       w = N_W'(2);
            3:       w = N_W'(64);
            4:       w = N_W'(127);
            5:       w = N_W'(8);
            6:       w = N_W'(1);
            7:       w = N_W'(45);
            8:       w = N_W'(3);
            9:       w = N_W'(63);
            default: w = WINDOW_DEFAULT;
        endcase
        return w;
    endfunction

    // build one random bar
    function automatic t_bar make_bar(input int unsigned phase);
        t_bar               b;
        logic [PRICE_W-1:0] base;
        logic [PRICE_W-1:0] spread;
        int unsigned        kind;
        base   = PRICE_W'($urandom_range(0, 32'h7FFF_0000));
        spread = PRICE_W'($urandom_range(0, 4000));
        kind   = (phase == FLAT_PHASE) ? KIND_FLAT : $urandom_range(KIND_EXTREME, KIND_LAST);
        unique case (kind)
            KIND_FLAT: begin
                b.bar_high  = base;
                b.bar_low   = base;
                b.bar_open  = base;
                b.bar_close = base + spread;
            end
            KIND_EXTREME: begin
                b.bar_high  = '1;
                b.bar_low   = '0;
                if ($urandom_range(0, 1) == 1) begin
                    b.bar_high = '0;
                    b.bar_low  = '1;
                end
                b.bar_open  = PRICE_W'($urandom());
                b.bar_close = PRICE_W'($urandom());
            end
            KIND_INVERTED: begin
                b.bar_high  = base;
                b.bar_low   = base + spread;
                b.bar_open  = base + spread;
                b.bar_close = base;
            end
            KIND_BIG_BODY: begin
                b.bar_high  = base + PRICE_W'(10);
                b.bar_low   = base;
                b.bar_open  = base;
                b.bar_close = base + spread * PRICE_W'(50);
            end
            default: begin
                b.bar_high  = base + spread;
                b.bar_low   = base;
                b.bar_open  = base + PRICE_W'($urandom_range(0, spread));
                b.bar_close = base + PRICE_W'($urandom_range(0, spread));
            end
        endcase
        return b;
    endfunction

    // offer one bar and hold it until the transfer
    task automatic send_bar(input t_bar b);
        @(negedge i_clk);
        bar_ch.valid     = 1'b1;
        bar_ch.bar_high  = b.bar_high;
        bar_ch.bar_low   = b.bar_low;
        bar_ch.bar_open  = b.bar_open;
        bar_ch.bar_close = b.bar_close;
        @(posedge i_clk);
        while (!bar_ch.ready) begin
            @(posedge i_clk);
        end
    endtask

    // drop valid for a number of cycles
    task automatic idle_bar(input int unsigned cycles);
        @(negedge i_clk);
        bar_ch.valid = 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // write the window once nothing is in flight
    task automatic write_window(input logic [N_W-1:0] value);
        @(negedge i_clk);
        bar_ch.valid = 1'b0;
        while (sb.expected_markers.size() != 0) begin
            @(negedge i_clk);
        end
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        windows_used++;
    endtask

    // drive the result ready: long holds on request, random short holds while idling is on
    task automatic run_receiver();
        @(negedge i_clk);
        forever begin
            if (hold_request) begin
                marker_ch.ready = 1'b0;
                for (int unsigned c = 0; c < LONG_HOLD; c++) begin
                    @(negedge i_clk);
                end
                hold_request = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                marker_ch.ready = 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
            end else begin
                marker_ch.ready = 1'b1;
                @(negedge i_clk);
            end
        end
    endtask

    // check every transfer and stop a stalled run
    always @(posedge i_clk) begin : monitor
        t_bar seen;
        if (i_rst_n) begin
            if (bar_ch.valid && bar_ch.ready) begin
                seen.bar_high  = bar_ch.bar_high;
                seen.bar_low   = bar_ch.bar_low;
                seen.bar_open  = bar_ch.bar_open;
                seen.bar_close = bar_ch.bar_close;
                sb.take_bar(seen);
            end
            if (marker_ch.valid && marker_ch.ready) begin
                sb.check_marker(marker_ch.marker_size);
            end
            if (i_cfg_we) begin
                sb.window_setting = i_cfg_wdata;
            end
            if ((bar_ch.valid && bar_ch.ready) || (marker_ch.valid && marker_ch.ready)
                || i_cfg_we) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                sb.report($sformatf("no transfer for %0d cycles", quiet_cycles));
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        bar_ch.valid     = 1'b0;
        bar_ch.bar_high  = '0;
        bar_ch.bar_low   = '0;
        bar_ch.bar_open  = '0;
        bar_ch.bar_close = '0;
        marker_ch.ready  = 1'b0;
        idle_on          = 1'b1;
        hold_request     = 1'b0;
        long_hold        = 0;
        bars_sent        = 0;
        windows_used     = 0;
        quiet_cycles     = 0;
        sb               = new();

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        fork
            run_receiver();
        join_none

        for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
            // no idling in the last part of the run
            if (phase >= PHASE_COUNT - 2) begin
                idle_on = 1'b0;
            end
            if (phase > 0) begin
                write_window(window_for_phase(phase));
            end
            if (phase == PRESSURE_PHASE) begin
                hold_request = 1'b1;
                long_hold++;
            end
            for (int unsigned i = 0; i < PHASE_BARS; i++) begin
                send_bar(make_bar(phase));
                bars_sent++;
                if (idle_on && $urandom_range(0, 3) == 0) begin
                    idle_bar($urandom_range(1, 17));
                end
            end
        end

        // drain the remaining results
        @(negedge i_clk);
        bar_ch.valid = 1'b0;
        while (sb.expected_markers.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Run drove %0d bars, checked %0d marker sizes over %0d window settings,",
                 bars_sent, sb.markers_seen, windows_used);
        $display("with flat, inverted and full-scale bars and %0d long output stall(s).",
                 long_hold);
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
